FILE: src/assert_macros.svh
// Assertion macros used by the checker file of the block.
// Every macro samples on clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define LFU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define LFU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/lfu_pkg.sv
// Shared types and constants of the LFU cache table.
// No dependencies; used by the controller, the datapath and the top level.
package lfu_pkg;

  localparam int DEF_ENTRIES    = 16;
  localparam int DEF_COUNT_BITS = 16;
  localparam int KEY_BITS       = 32;
  localparam int VALUE_BITS     = 32;
  localparam int CAP_BITS       = 5;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_END,
    ST_DECIDE,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;      // capture the request word
    logic scan_rd;   // read entry idx for the match/victim scan
    logic sweep_rd;  // read entry idx for the rank rewrite
    logic decide;    // commit hit, insert or eviction
    logic out_load;  // move the result into the output register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic need_sweep;  // ranks change for this request
  } status_t;

endpackage

FILE: src/lfu_ctrl.sv
// Controller state machine of the LFU cache table.
// Depends on lfu_pkg; drives lfu_dpath through cmd_t and reads status_t.
module lfu_ctrl import lfu_pkg::*; #(
  parameter int ENTRIES = DEF_ENTRIES,
  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output cmd_t                cmd,
  input  status_t             status,
  output logic [IDX_BITS-1:0] idx
);

  localparam logic [IDX_BITS-1:0] LAST = IDX_BITS'(ENTRIES - 1);

  state_t              state, state_next;
  logic [IDX_BITS-1:0] idx_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          idx_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = ST_SCAN_END;
        end else begin
          idx_next = idx + IDX_BITS'(1);
        end
      end
      ST_SCAN_END: begin
        state_next = ST_DECIDE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = status.need_sweep ? ST_SWEEP : ST_DONE;
      end
      ST_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        if (idx == LAST) begin
          idx_next   = '0;
          state_next = ST_SWEEP_END;
        end else begin
          idx_next = idx + IDX_BITS'(1);
        end
      end
      ST_SWEEP_END: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/lfu_dpath.sv
// Datapath of the LFU cache table: entry memories, valid bits, scan trackers,
// rank rewrite and output register. Depends on lfu_pkg; steered by lfu_ctrl.
module lfu_dpath import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  localparam int IDX_BITS  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cmd_t                         cmd,
  input  logic [IDX_BITS-1:0]          idx,
  output status_t                      status,
  input  logic                         cfg_wr_en,
  input  logic [CAP_BITS-1:0]          cfg_wr_data,
  input  logic                         opcode,
  input  logic signed [KEY_BITS-1:0]   lookup_key,
  input  logic signed [VALUE_BITS-1:0] write_value,
  output logic                         hit,
  output logic signed [VALUE_BITS-1:0] read_value,
  output logic                         evicted,
  output logic signed [KEY_BITS-1:0]   evicted_key
);

  localparam int OCC_BITS = $clog2(ENTRIES + 1);
  localparam int CMP_BITS = (OCC_BITS > CAP_BITS) ? OCC_BITS : CAP_BITS;

  // Entry storage
  logic [KEY_BITS-1:0]   key_mem   [ENTRIES];
  logic [VALUE_BITS-1:0] value_mem [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_mem   [ENTRIES];
  logic [IDX_BITS-1:0]   rank_mem  [ENTRIES];
  logic [ENTRIES-1:0]    valid;
  logic [OCC_BITS-1:0]   occ;
  logic [CAP_BITS-1:0]   cap;

  // Registered read data and the index it belongs to
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [IDX_BITS-1:0]   rank_q;
  logic [IDX_BITS-1:0]   eval_idx;
  logic                  scan_pend, sweep_pend;

  // Request
  logic                  req_op;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_value;

  // Scan trackers
  logic                  found, free_ok, vic_ok;
  logic [IDX_BITS-1:0]   found_idx, free_idx, vic_idx;
  logic [IDX_BITS-1:0]   found_rank, vic_rank;
  logic [COUNT_BITS-1:0] found_cnt, vic_cnt;
  logic [VALUE_BITS-1:0] found_val;
  logic [KEY_BITS-1:0]   vic_key;

  // Decision and its registered copy
  logic                  is_put, room, better;
  logic [CMP_BITS-1:0]   cap_ext, eff_cap;
  logic [IDX_BITS-1:0]   d_tgt, d_limit;
  logic                  d_inc_all, d_ev, d_grow;
  logic [COUNT_BITS-1:0] cnt_bumped;
  logic [IDX_BITS-1:0]   tgt, limit;
  logic                  inc_all;
  logic                  res_hit, res_ev;
  logic [VALUE_BITS-1:0] res_rd;
  logic [KEY_BITS-1:0]   res_evk;
  logic                  rank_we;
  logic [IDX_BITS-1:0]   rank_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_op    <= opcode;
      req_key   <= lookup_key;
      req_value <= write_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_pend  <= 1'b0;
      sweep_pend <= 1'b0;
    end else begin
      scan_pend  <= cmd.scan_rd;
      sweep_pend <= cmd.sweep_rd;
    end
  end

  always_ff @(posedge clk) begin
    eval_idx <= idx;
  end

  // Memory ports: one read at idx, one write
  always_ff @(posedge clk) begin
    if (cmd.decide && !found && is_put) begin
      key_mem[d_tgt] <= req_key;
    end
    if (cmd.scan_rd || cmd.sweep_rd) begin
      key_q <= key_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && is_put) begin
      value_mem[d_tgt] <= req_value;
    end
    if (cmd.scan_rd || cmd.sweep_rd) begin
      value_q <= value_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && (found || is_put)) begin
      cnt_mem[d_tgt] <= found ? cnt_bumped : '0;
    end
    if (cmd.scan_rd || cmd.sweep_rd) begin
      cnt_q <= cnt_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rank_we) begin
      rank_mem[eval_idx] <= rank_new;
    end
    if (cmd.scan_rd || cmd.sweep_rd) begin
      rank_q <= rank_mem[idx];
    end
  end

  // Scan: first valid match, first free slot, lowest count then oldest
  assign better = !vic_ok || (cnt_q < vic_cnt) || ((cnt_q == vic_cnt) && (rank_q > vic_rank));

  always_ff @(posedge clk) begin
    if (rst) begin
      found   <= 1'b0;
      free_ok <= 1'b0;
      vic_ok  <= 1'b0;
    end else if (cmd.load) begin
      found   <= 1'b0;
      free_ok <= 1'b0;
      vic_ok  <= 1'b0;
    end else if (scan_pend) begin
      if (valid[eval_idx] && (key_q == req_key) && !found) begin
        found      <= 1'b1;
        found_idx  <= eval_idx;
        found_rank <= rank_q;
        found_cnt  <= cnt_q;
        found_val  <= value_q;
      end
      if (!valid[eval_idx] && !free_ok) begin
        free_ok  <= 1'b1;
        free_idx <= eval_idx;
      end
      if (valid[eval_idx] && better) begin
        vic_ok   <= 1'b1;
        vic_idx  <= eval_idx;
        vic_cnt  <= cnt_q;
        vic_rank <= rank_q;
        vic_key  <= key_q;
      end
    end
  end

  // Decision
  assign is_put            = (req_op == OP_PUT);
  assign status.need_sweep = found || is_put;
  assign cnt_bumped        = (&found_cnt) ? found_cnt : found_cnt + COUNT_BITS'(1);

  always_comb begin
    cap_ext = CMP_BITS'(cap);
    if (cap_ext == '0) begin
      eff_cap = CMP_BITS'(1);
    end else if (cap_ext > CMP_BITS'(ENTRIES)) begin
      eff_cap = CMP_BITS'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
    room = (CMP_BITS'(occ) < eff_cap) && free_ok;
  end

  // Ranks below the target's rank move up; an insert into a free slot moves all.
  // An eviction reuses the victim's slot, so ranks above it stay put.
  always_comb begin
    d_tgt     = found_idx;
    d_limit   = found_rank;
    d_inc_all = 1'b0;
    d_ev      = 1'b0;
    d_grow    = 1'b0;
    if (!found) begin
      if (room) begin
        d_tgt     = free_idx;
        d_inc_all = 1'b1;
        d_grow    = 1'b1;
      end else if (vic_ok) begin
        d_tgt   = vic_idx;
        d_limit = vic_rank;
        d_ev    = 1'b1;
      end else begin
        d_tgt     = '0;
        d_inc_all = 1'b1;
        d_grow    = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      tgt     <= d_tgt;
      limit   <= d_limit;
      inc_all <= d_inc_all;
      res_hit <= found;
      res_rd  <= (found && !is_put) ? found_val : '0;
      res_ev  <= !found && is_put && d_ev;
      res_evk <= (!found && is_put && d_ev) ? vic_key : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      occ   <= '0;
    end else if (cmd.decide && !found && is_put && d_grow) begin
      valid[d_tgt] <= 1'b1;
      occ          <= occ + OCC_BITS'(1);
    end
  end

  // Rank rewrite, one entry a cycle
  always_comb begin
    rank_we  = sweep_pend && (valid[eval_idx] || (eval_idx == tgt));
    rank_new = rank_q;
    if (eval_idx == tgt) begin
      rank_new = '0;
    end else if (inc_all || (rank_q < limit)) begin
      rank_new = rank_q + IDX_BITS'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      hit         <= res_hit;
      read_value  <= res_rd;
      evicted     <= res_ev;
      evicted_key <= res_evk;
    end
  end

endmodule

FILE: src/lfu_cache_table.sv
// LFU cache table, least-recently-touched tie break. Each request runs a scan
// pass, a commit and, for a get hit or any put, a rank rewrite pass before its
// result word is valid. One word in flight: no new request is taken until the
// result word is loaded. Both passes use the single read port of the entry
// memories, one entry per cycle.
// Reset clears valid bits and occupancy and sets capacity to 16; no clear pass.
module lfu_cache_table import lfu_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration: capacity_in_use
  input  logic                         cfg_wr_en,
  input  logic [CAP_BITS-1:0]          cfg_wr_data,
  // Request channel
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         opcode,
  input  logic signed [KEY_BITS-1:0]   lookup_key,
  input  logic signed [VALUE_BITS-1:0] write_value,
  // Result channel
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         hit,
  output logic signed [VALUE_BITS-1:0] read_value,
  output logic                         evicted,
  output logic signed [KEY_BITS-1:0]   evicted_key
);

  localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  cmd_t                cmd;
  status_t             status;
  logic [IDX_BITS-1:0] idx;

  // Sequence the request: accept, scan all entries, commit, rewrite ranks unless
  // a get misses, then hand the result word to the output register. The request
  // side reopens as soon as the word is loaded, even while it waits for out_ready.
  lfu_ctrl #(
    .ENTRIES (ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .idx       (idx)
  );

  // Hold keys, values, use counts and recency ranks; track the match and the
  // victim during the scan; drive the result word.
  lfu_dpath #(
    .ENTRIES    (ENTRIES),
    .COUNT_BITS (COUNT_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .idx         (idx),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .opcode      (opcode),
    .lookup_key  (lookup_key),
    .write_value (write_value),
    .hit         (hit),
    .read_value  (read_value),
    .evicted     (evicted),
    .evicted_key (evicted_key)
  );

endmodule

FILE: src/lfu_checker.sv
// Port-level checks of the LFU cache table, bound to the top level below.
// Depends on assert_macros.svh and lfu_pkg.
`include "assert_macros.svh"

module lfu_checker import lfu_pkg::*; (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         hit,
  input logic signed [VALUE_BITS-1:0] read_value,
  input logic                         evicted,
  input logic signed [KEY_BITS-1:0]   evicted_key
);

  `LFU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit) && $stable(read_value) && $stable(evicted) && $stable(evicted_key), "result word changed while stalled")
  `LFU_ASSERT_IMP(a_evict_miss, out_valid && evicted, !hit, "eviction reported on a hit")
  `LFU_ASSERT_IMP(a_evkey_zero, out_valid && !evicted, evicted_key == '0, "evicted key not zero")
  `LFU_ASSERT_IMP(a_rd_zero, out_valid && !hit, read_value == '0, "read value not zero on miss")
  `LFU_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "request taken while busy")

endmodule

bind lfu_cache_table lfu_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .hit         (hit),
  .read_value  (read_value),
  .evicted     (evicted),
  .evicted_key (evicted_key)
);
